FILE: design/rdp_pkg.sv
`timescale 1ns / 1ps
package rdp_pkg;

	localparam int MAX_FIGURES_DEF = 64;
	localparam int MAX_DIM_DEF     = 1024;
	localparam int QUEUE_DEPTH     = 2;

	localparam int COORD_W = 12;
	localparam int EXT_W   = 11;
	localparam int SHADE_W = 8;
	localparam int DIM_W   = 11;
	localparam int TOTAL_W = 7;

	localparam logic [DIM_W-1:0] WIDTH_RST  = 11'd1024;
	localparam logic [DIM_W-1:0] HEIGHT_RST = 11'd1024;

	typedef enum logic [1:0] {
		CMD_CLEAR = 2'd0,
		CMD_RECT  = 2'd1,
		CMD_DISK  = 2'd2,
		CMD_QUERY = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		ST_OK      = 2'd0,
		ST_FULL    = 2'd1,
		ST_OUTSIDE = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		CFG_WIDTH      = 2'd0,
		CFG_HEIGHT     = 2'd1,
		CFG_BACKGROUND = 2'd2
	} cfg_idx_t;

	typedef enum logic {
		BK_IDLE,
		BK_SCAN
	} back_state_t;

	// classified command as it travels from front to back
	typedef struct packed {
		cmd_t                      cmd;
		logic signed [COORD_W-1:0] x;
		logic signed [COORD_W-1:0] y;
		logic [EXT_W-1:0]          ea;
		logic [EXT_W-1:0]          eb;
		logic [SHADE_W-1:0]        shade;
		logic                      outside;
	} entry_t;

	typedef struct packed {
		logic                      is_disk;
		logic signed [COORD_W-1:0] x;
		logic signed [COORD_W-1:0] y;
		logic [EXT_W-1:0]          ea;
		logic [EXT_W-1:0]          eb;
		logic [SHADE_W-1:0]        shade;
	} fig_t;

	// handshake between queue and back end
	typedef struct packed {
		logic valid;
		logic pop;
	} q_ctl_t;

endpackage

FILE: design/rdp_front.sv
`timescale 1ns / 1ps
module rdp_front import rdp_pkg::*; #(
	parameter int MAX_DIM = MAX_DIM_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_stall,
	input  logic [1:0]                cmd,
	input  logic signed [COORD_W-1:0] pos_x,
	input  logic signed [COORD_W-1:0] pos_y,
	input  logic [EXT_W-1:0]          extent_a,
	input  logic [EXT_W-1:0]          extent_b,
	input  logic [SHADE_W-1:0]        shade,
	input  logic [DIM_W-1:0]          image_width,
	input  logic [DIM_W-1:0]          image_height,
	output logic                      push_valid,
	input  logic                      push_ready,
	output entry_t                    push_entry
);

	localparam logic [COORD_W-1:0] DIM_LIM = COORD_W'(MAX_DIM);

	logic               vld_s1;
	entry_t             entry_s1;
	entry_t             entry_d;
	logic               accept;
	logic [COORD_W-1:0] w_lim, h_lim;
	cmd_t               cmd_in;

	assign cmd_in = cmd_t'(cmd);

	always_comb begin
		w_lim = ({1'b0, image_width} > DIM_LIM) ? DIM_LIM : {1'b0, image_width};
		h_lim = ({1'b0, image_height} > DIM_LIM) ? DIM_LIM : {1'b0, image_height};
		entry_d.cmd     = cmd_in;
		entry_d.x       = pos_x;
		entry_d.y       = pos_y;
		entry_d.ea      = extent_a;
		entry_d.eb      = (cmd_in == CMD_DISK) ? '0 : extent_b;
		entry_d.shade   = shade;
		// negative coordinates have the top bit set, so they also fail the limit compare
		entry_d.outside = pos_x[COORD_W-1] | pos_y[COORD_W-1] |
			($unsigned(pos_x) >= w_lim) | ($unsigned(pos_y) >= h_lim);
	end

	assign in_stall   = vld_s1 & ~push_ready;
	assign accept     = in_valid & ~in_stall;
	assign push_valid = vld_s1;
	assign push_entry = entry_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (accept) begin
			vld_s1 <= 1'b1;
		end else if (push_ready) begin
			vld_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			entry_s1 <= entry_d;
		end
	end

endmodule

FILE: design/rdp_queue.sv
`timescale 1ns / 1ps
module rdp_queue import rdp_pkg::*; #(
	parameter int DEPTH = QUEUE_DEPTH
) (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   push_valid,
	output logic   push_ready,
	input  entry_t push_entry,
	output q_ctl_t ctl_out,
	input  logic   pop,
	output entry_t head
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int FW = $clog2(DEPTH + 1);

	entry_t          slot_q [DEPTH];
	logic [PW-1:0]   wr_ptr_q, rd_ptr_q;
	logic [FW-1:0]   fill_q;
	logic            do_push, do_pop;

	assign push_ready    = (fill_q != FW'(DEPTH));
	assign do_push       = push_valid & push_ready;
	assign do_pop        = pop & (fill_q != '0);
	assign ctl_out.valid = (fill_q != '0);
	assign ctl_out.pop   = do_pop;
	assign head          = slot_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				fill_q <= fill_q + 1'b1;
			end else if (do_pop && !do_push) begin
				fill_q <= fill_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_ptr_q] <= push_entry;
		end
	end

endmodule

FILE: design/rdp_back.sv
`timescale 1ns / 1ps
module rdp_back import rdp_pkg::*; #(
	parameter int MAX_FIGURES = MAX_FIGURES_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  q_ctl_t             q_ctl,
	input  entry_t             q_entry,
	output logic               q_pop,
	input  logic [SHADE_W-1:0] bg_color,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [SHADE_W-1:0] pixel_color,
	output logic [1:0]         status,
	output logic [TOTAL_W-1:0] figure_total
);

	localparam int CW = $clog2(MAX_FIGURES + 1);
	localparam int AW = (MAX_FIGURES > 1) ? $clog2(MAX_FIGURES) : 1;
	localparam logic [CW-1:0] CNT_MAX = CW'(MAX_FIGURES);

	fig_t mem [MAX_FIGURES];

	back_state_t state_q, state_nxt;
	logic [CW-1:0] count_q, count_nxt, idx_q;
	logic signed [COORD_W-1:0] cur_x_q, cur_y_q;
	logic [SHADE_W-1:0] color_q;

	logic out_vld_q;
	logic [SHADE_W-1:0] out_color_q;
	status_t out_status_q;
	logic [TOTAL_W-1:0] out_total_q;

	logic out_free, load_out, start_scan, wr_en, issue, scan_done;
	logic [SHADE_W-1:0] res_color;
	status_t res_status;
	fig_t wr_fig;

	// scan pipeline: read data, products and compares, accumulate
	logic rd_vld_s1;
	fig_t fig_s1;
	logic vld_s2, disk_s2, rect_s2;
	logic signed [2*COORD_W+1:0] dxx_s2, dyy_s2;
	logic [2*EXT_W-1:0] rr_s2;
	logic [SHADE_W-1:0] shade_s2;

	logic signed [COORD_W:0] dx, dy, fx, fy, fx_end, fy_end, cx, cy;
	logic rect_hit;
	logic signed [2*COORD_W+2:0] dist2;
	logic hit;

	assign out_free  = ~out_vld_q | ~out_stall;
	assign issue     = (state_q == BK_SCAN) && (idx_q != count_q);
	assign scan_done = (state_q == BK_SCAN) && (idx_q == count_q) && !rd_vld_s1 && !vld_s2;

	always_comb begin
		wr_fig.is_disk = (q_entry.cmd == CMD_DISK);
		wr_fig.x       = q_entry.x;
		wr_fig.y       = q_entry.y;
		wr_fig.ea      = q_entry.ea;
		wr_fig.eb      = q_entry.eb;
		wr_fig.shade   = q_entry.shade;
	end

	always_comb begin
		state_nxt = state_q;
		case (state_q)
			BK_IDLE: if (start_scan) begin
				state_nxt = BK_SCAN;
			end
			BK_SCAN: if (scan_done) begin
				state_nxt = BK_IDLE;
			end
			default: state_nxt = BK_IDLE;
		endcase
	end

	always_comb begin
		q_pop      = 1'b0;
		load_out   = 1'b0;
		start_scan = 1'b0;
		wr_en      = 1'b0;
		count_nxt  = count_q;
		res_color  = '0;
		res_status = ST_OK;
		case (state_q)
			BK_IDLE: if (q_ctl.valid && out_free) begin
				q_pop = 1'b1;
				case (q_entry.cmd)
					CMD_CLEAR: begin
						load_out  = 1'b1;
						count_nxt = '0;
					end
					CMD_RECT, CMD_DISK: begin
						load_out = 1'b1;
						if (count_q == CNT_MAX) begin
							res_status = ST_FULL;
						end else begin
							wr_en     = 1'b1;
							count_nxt = count_q + 1'b1;
						end
					end
					CMD_QUERY: begin
						if (q_entry.outside) begin
							load_out   = 1'b1;
							res_status = ST_OUTSIDE;
						end else begin
							start_scan = 1'b1;
						end
					end
					default: ;
				endcase
			end
			BK_SCAN: if (scan_done) begin
				load_out  = 1'b1;
				res_color = color_q;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= BK_IDLE;
			count_q   <= '0;
			idx_q     <= '0;
			rd_vld_s1 <= 1'b0;
			vld_s2    <= 1'b0;
			out_vld_q <= 1'b0;
		end else begin
			state_q   <= state_nxt;
			count_q   <= count_nxt;
			rd_vld_s1 <= issue;
			vld_s2    <= rd_vld_s1;
			if (start_scan) begin
				idx_q <= '0;
			end else if (issue) begin
				idx_q <= idx_q + 1'b1;
			end
			if (load_out) begin
				out_vld_q <= 1'b1;
			end else if (!out_stall) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	// figure memory
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[count_q[AW-1:0]] <= wr_fig;
		end
	end

	always_ff @(posedge clk) begin
		if (issue) begin
			fig_s1 <= mem[idx_q[AW-1:0]];
		end
	end

	always_comb begin
		cx       = {cur_x_q[COORD_W-1], cur_x_q};
		cy       = {cur_y_q[COORD_W-1], cur_y_q};
		fx       = {fig_s1.x[COORD_W-1], fig_s1.x};
		fy       = {fig_s1.y[COORD_W-1], fig_s1.y};
		fx_end   = fx + $signed({2'b00, fig_s1.ea});
		fy_end   = fy + $signed({2'b00, fig_s1.eb});
		dx       = cx - fx;
		dy       = cy - fy;
		rect_hit = (cx >= fx) && (cx < fx_end) && (cy >= fy) && (cy < fy_end);
	end

	always_ff @(posedge clk) begin
		if (rd_vld_s1) begin
			dxx_s2   <= dx * dx;
			dyy_s2   <= dy * dy;
			rr_s2    <= fig_s1.ea * fig_s1.ea;
			disk_s2  <= fig_s1.is_disk;
			rect_s2  <= rect_hit;
			shade_s2 <= fig_s1.shade;
		end
	end

	always_comb begin
		dist2 = {dxx_s2[2*COORD_W+1], dxx_s2} + {dyy_s2[2*COORD_W+1], dyy_s2};
		hit   = disk_s2 ? (dist2 <= $signed({5'b0, rr_s2})) : rect_s2;
	end

	always_ff @(posedge clk) begin
		if (start_scan) begin
			cur_x_q <= q_entry.x;
			cur_y_q <= q_entry.y;
			color_q <= bg_color;
		end else if (vld_s2 && hit) begin
			// later figures overwrite earlier ones
			color_q <= shade_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			out_color_q  <= res_color;
			out_status_q <= res_status;
			out_total_q  <= TOTAL_W'(count_nxt);
		end
	end

	assign out_valid    = out_vld_q;
	assign pixel_color  = out_color_q;
	assign status       = out_status_q;
	assign figure_total = out_total_q;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_MAX)
		else $error("figure count above table size");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		load_out |-> (!out_vld_q || !out_stall))
		else $error("result register overwritten while stalled");

	a_write_room: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en |-> (count_q < CNT_MAX))
		else $error("figure write into full table");

	a_pop_idle: assert property (@(posedge clk) disable iff (!arst_n)
		q_ctl.pop |-> (state_q == BK_IDLE))
		else $error("queue popped during scan");

	a_scan_read: assert property (@(posedge clk) disable iff (!arst_n)
		rd_vld_s1 |-> (state_q == BK_SCAN))
		else $error("figure read outside scan");

endmodule

FILE: design/rect_disk_painter_rasterizer_unit.sv
`timescale 1ns / 1ps
// Painter's-order rasterizer for filled rectangles and disks.
// Input channel (in_valid/in_stall): cmd with pos_x, pos_y, extent_a, extent_b,
// shade. Commands clear the figure table, append a rectangle or disk, or query
// one pixel. Every input transfer yields exactly one result on the output
// channel (out_valid/out_stall): pixel_color, status, figure_total.
// Config channel (cfg_valid/cfg_ready, always ready): index 0 image width,
// 1 image height, 2 background color. Write only while the block is idle.
// Clear, append and out-of-image queries pass the front register, the queue
// and the output register, and can be taken one per cycle while out_stall is
// low. An in-image query scans the figure memory one entry per cycle through
// a three-stage compare pipeline, over the N stored figures (N up to MAX_FIGURES).
// The back end pops no new command until the scan is done.
// A front stage and a two-entry queue keep accepting input while the back end
// scans or while a result waits in the output register.
// Reset: figure count cleared, width and height 1024, background 0. The
// figure memory itself is not cleared; entries above the count are never read.
// When out_stall is high the result holds and the back end stops popping; the
// queue then fills and in_stall rises.
module rect_disk_painter_rasterizer_unit import rdp_pkg::*; #(
	parameter int MAX_FIGURES = MAX_FIGURES_DEF,
	parameter int MAX_DIM     = MAX_DIM_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_stall,
	input  logic [1:0]                cmd,
	input  logic signed [COORD_W-1:0] pos_x,
	input  logic signed [COORD_W-1:0] pos_y,
	input  logic [EXT_W-1:0]          extent_a,
	input  logic [EXT_W-1:0]          extent_b,
	input  logic [SHADE_W-1:0]        shade,
	output logic                      out_valid,
	input  logic                      out_stall,
	output logic [SHADE_W-1:0]        pixel_color,
	output logic [1:0]                status,
	output logic [TOTAL_W-1:0]        figure_total,
	input  logic                      cfg_valid,
	output logic                      cfg_ready,
	input  logic [1:0]                cfg_index,
	input  logic [DIM_W-1:0]          cfg_data
);

	logic [DIM_W-1:0]   width_q, height_q;
	logic [SHADE_W-1:0] bg_q;

	logic   push_valid, push_ready, q_pop;
	entry_t push_entry, q_head;
	q_ctl_t q_ctl;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= WIDTH_RST;
			height_q <= HEIGHT_RST;
			bg_q     <= '0;
		end else if (cfg_valid) begin
			case (cfg_idx_t'(cfg_index))
				CFG_WIDTH:      width_q  <= cfg_data;
				CFG_HEIGHT:     height_q <= cfg_data;
				CFG_BACKGROUND: bg_q     <= cfg_data[SHADE_W-1:0];
				default: ;
			endcase
		end
	end

	rdp_front #(
		.MAX_DIM(MAX_DIM)
	) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.cmd          (cmd),
		.pos_x        (pos_x),
		.pos_y        (pos_y),
		.extent_a     (extent_a),
		.extent_b     (extent_b),
		.shade        (shade),
		.image_width  (width_q),
		.image_height (height_q),
		.push_valid   (push_valid),
		.push_ready   (push_ready),
		.push_entry   (push_entry)
	);

	rdp_queue #(
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_entry (push_entry),
		.ctl_out    (q_ctl),
		.pop        (q_pop),
		.head       (q_head)
	);

	rdp_back #(
		.MAX_FIGURES(MAX_FIGURES)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.q_ctl        (q_ctl),
		.q_entry      (q_head),
		.q_pop        (q_pop),
		.bg_color     (bg_q),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.pixel_color  (pixel_color),
		.status       (status),
		.figure_total (figure_total)
	);

endmodule

FILE: sim/tb_top.sv
`timescale 1ns / 1ps
module tb_top;
	import rdp_pkg::*;

	localparam int MAX_FIG     = MAX_FIGURES_DEF;
	localparam int DIM_CAP     = MAX_DIM_DEF;
	localparam int CYCLE_LIMIT = 600000;
	localparam int SQUEEZE_LEN = 400;
	localparam int TAIL_WAIT   = MAX_FIG + 16;

	typedef struct packed {
		cmd_t               cmd;
		logic [COORD_W-1:0] x;
		logic [COORD_W-1:0] y;
		logic [EXT_W-1:0]   ea;
		logic [EXT_W-1:0]   eb;
		logic [SHADE_W-1:0] sh;
	} item_t;

	typedef struct packed {
		logic [SHADE_W-1:0] color;
		status_t            status;
		logic [TOTAL_W-1:0] total;
	} reply_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	logic                      in_valid = 1'b0;
	logic                      in_stall;
	logic [1:0]                cmd = '0;
	logic signed [COORD_W-1:0] pos_x = '0;
	logic signed [COORD_W-1:0] pos_y = '0;
	logic [EXT_W-1:0]          extent_a = '0;
	logic [EXT_W-1:0]          extent_b = '0;
	logic [SHADE_W-1:0]        shade = '0;
	logic                      out_valid;
	logic                      out_stall = 1'b0;
	logic [SHADE_W-1:0]        pixel_color;
	logic [1:0]                status;
	logic [TOTAL_W-1:0]        figure_total;
	logic                      cfg_valid = 1'b0;
	logic                      cfg_ready;
	logic [1:0]                cfg_index = '0;
	logic [DIM_W-1:0]          cfg_data = '0;

	rect_disk_painter_rasterizer_unit DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.cmd          (cmd),
		.pos_x        (pos_x),
		.pos_y        (pos_y),
		.extent_a     (extent_a),
		.extent_b     (extent_b),
		.shade        (shade),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.pixel_color  (pixel_color),
		.status       (status),
		.figure_total (figure_total),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	always #6 clk = ~clk;

	// predictor state: figure table and register copies
	fig_t             shape_tbl [MAX_FIG];
	int               shape_cnt = 0;
	logic [DIM_W-1:0] img_w = WIDTH_RST;
	logic [DIM_W-1:0] img_h = HEIGHT_RST;
	logic [7:0]       bg_gray = '0;

	item_t  cmd_backlog [$];
	reply_t replies_due [$];
	item_t  cur_item;

	int items_made = 0;
	int n_done = 0;
	int errors = 0;
	int cycles = 0;
	int hold_left = 0;
	int squeeze_asks = 0;
	int squeeze_seen = 0;
	logic calm = 1'b0;

	function automatic reply_t paint_reply(input item_t it);
		reply_t r;
		longint px, py, fx, fy, ea_l, eb_l, w, h;
		logic hit;
		int k;
		r.color = '0;
		r.status = ST_OK;
		px = $signed(it.x);
		py = $signed(it.y);
		case (it.cmd)
			CMD_CLEAR: shape_cnt = 0;
			CMD_RECT, CMD_DISK: begin
				if (shape_cnt >= MAX_FIG) begin
					r.status = ST_FULL;
				end else begin
					shape_tbl[shape_cnt].is_disk = (it.cmd == CMD_DISK);
					shape_tbl[shape_cnt].x = it.x;
					shape_tbl[shape_cnt].y = it.y;
					shape_tbl[shape_cnt].ea = it.ea;
					shape_tbl[shape_cnt].eb = (it.cmd == CMD_DISK) ? '0 : it.eb;
					shape_tbl[shape_cnt].shade = it.sh;
					shape_cnt++;
				end
			end
			default: begin
				w = (img_w > DIM_CAP) ? DIM_CAP : img_w;
				h = (img_h > DIM_CAP) ? DIM_CAP : img_h;
				if (px < 0 || py < 0 || px >= w || py >= h) begin
					r.status = ST_OUTSIDE;
				end else begin
					r.color = bg_gray;
					// later figures paint over earlier ones
					for (k = 0; k < shape_cnt; k++) begin
						fx = $signed(shape_tbl[k].x);
						fy = $signed(shape_tbl[k].y);
						ea_l = shape_tbl[k].ea;
						eb_l = shape_tbl[k].eb;
						if (shape_tbl[k].is_disk)
							hit = (px - fx) * (px - fx) + (py - fy) * (py - fy) <= ea_l * ea_l;
						else
							hit = px >= fx && px < fx + ea_l && py >= fy && py < fy + eb_l;
						if (hit)
							r.color = shape_tbl[k].shade;
					end
				end
			end
		endcase
		r.total = 7'(shape_cnt);
		return r;
	endfunction

	// driver: predicts on every input transfer, then offers the next item
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && !in_stall)
				replies_due.push_back(paint_reply(cur_item));
			if (!in_valid || !in_stall) begin
				if (cmd_backlog.size() != 0 && (calm || $urandom_range(0, 99) >= 6)) begin
					cur_item = cmd_backlog.pop_front();
					in_valid <= 1'b1;
					cmd <= cur_item.cmd;
					pos_x <= cur_item.x;
					pos_y <= cur_item.y;
					extent_a <= cur_item.ea;
					extent_b <= cur_item.eb;
					shade <= cur_item.sh;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// monitor: checks each output transfer against the oldest prediction
	always @(posedge clk) begin : monitor
		reply_t want;
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				if (replies_due.size() == 0) begin
					errors++;
					$display("%0t: unexpected result: color %0d status %0d total %0d",
						$time, pixel_color, status, figure_total);
				end else begin
					want = replies_due.pop_front();
					n_done++;
					if (pixel_color !== want.color) begin
						errors++;
						$display("%0t: pixel_color expected %0d, actual %0d",
							$time, want.color, pixel_color);
					end
					if (status !== want.status) begin
						errors++;
						$display("%0t: status expected %0d, actual %0d",
							$time, want.status, status);
					end
					if (figure_total !== want.total) begin
						errors++;
						$display("%0t: figure_total expected %0d, actual %0d",
							$time, want.total, figure_total);
					end
				end
			end
		end
	end

	// receiver back-pressure
	always @(posedge clk) begin
		if (arst_n) begin
			if (hold_left != 0) begin
				hold_left <= hold_left - 1;
				out_stall <= 1'b1;
			end else if (squeeze_asks != squeeze_seen) begin
				// long hold-off so the input side backs up
				squeeze_seen <= squeeze_asks;
				hold_left <= SQUEEZE_LEN;
				out_stall <= 1'b1;
			end else begin
				out_stall <= !calm && ($urandom_range(0, 99) < 6);
			end
		end
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("== FAIL ==");
			$finish;
		end
	end

	function automatic void push_item(input cmd_t c, input int x, input int y,
		input int a, input int b, input int s);
		item_t it;
		it.cmd = c;
		it.x = x[COORD_W-1:0];
		it.y = y[COORD_W-1:0];
		it.ea = a[EXT_W-1:0];
		it.eb = b[EXT_W-1:0];
		it.sh = s[SHADE_W-1:0];
		cmd_backlog.push_back(it);
		items_made++;
	endfunction

	task automatic write_reg(input cfg_idx_t idx, input int val);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val[DIM_W-1:0];
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		case (idx)
			CFG_WIDTH:  img_w = val[DIM_W-1:0];
			CFG_HEIGHT: img_h = val[DIM_W-1:0];
			default:    bg_gray = val[7:0];
		endcase
	endtask

	task automatic drain();
		while (n_done != items_made)
			@(posedge clk);
	endtask

	// clear (usually), a batch of figures, then queries mostly aimed at them
	task automatic scene(input int nfig, input int nq);
		int cx [$];
		int cy [$];
		int span [$];
		int w, h, x, y, a, b, j, pick;
		cmd_t c;
		w = (img_w > DIM_CAP) ? DIM_CAP : img_w;
		h = (img_h > DIM_CAP) ? DIM_CAP : img_h;
		if (w < 1) w = 1;
		if (h < 1) h = 1;
		if ($urandom_range(0, 4) != 0)
			push_item(CMD_CLEAR, $urandom, $urandom, $urandom, $urandom, $urandom);
		repeat (nfig) begin
			c = $urandom_range(0, 1) ? CMD_DISK : CMD_RECT;
			if ($urandom_range(0, 9) == 0) begin
				x = $urandom_range(0, 4095);
				y = $urandom_range(0, 4095);
				a = $urandom_range(0, 2047);
				b = $urandom_range(0, 2047);
			end else begin
				x = $urandom_range(0, w + 20) - 10;
				y = $urandom_range(0, h + 20) - 10;
				a = (c == CMD_DISK) ? $urandom_range(0, w / 4 + 1) : $urandom_range(0, w / 3 + 1);
				b = $urandom_range(0, h / 3 + 1);
			end
			push_item(c, x, y, a, b, $urandom_range(0, 255));
			if (c == CMD_DISK) begin
				cx.push_back(x);
				cy.push_back(y);
				span.push_back(a);
			end else begin
				cx.push_back(x + a / 2);
				cy.push_back(y + b / 2);
				span.push_back(((a > b) ? a : b) / 2 + 1);
			end
		end
		repeat (nq) begin
			pick = $urandom_range(0, 99);
			if (pick < 6) begin
				push_item(cmd_t'($urandom_range(0, 3)), $urandom, $urandom, $urandom,
					$urandom, $urandom);
			end else if (pick < 70 && cx.size() != 0) begin
				j = $urandom_range(0, cx.size() - 1);
				x = cx[j] + $urandom_range(0, 2 * span[j] + 4) - span[j] - 2;
				y = cy[j] + $urandom_range(0, 2 * span[j] + 4) - span[j] - 2;
				push_item(CMD_QUERY, x, y, $urandom, $urandom, $urandom);
			end else if (pick < 92) begin
				push_item(CMD_QUERY, $urandom_range(0, w - 1), $urandom_range(0, h - 1),
					$urandom, $urandom, $urandom);
			end else begin
				push_item(CMD_QUERY, $urandom, $urandom, $urandom, $urandom, $urandom);
			end
		end
	endtask

	initial begin : stimulus
		int ph, quota, wv, hv;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset settings: 1024 x 1024, background 0
		push_item(CMD_QUERY, 0, 0, 0, 0, 0);
		push_item(CMD_QUERY, -1, 5, 0, 0, 0);
		push_item(CMD_QUERY, 5, -1, 0, 0, 0);
		push_item(CMD_QUERY, 1024, 0, 0, 0, 0);
		push_item(CMD_QUERY, 0, 1024, 0, 0, 0);
		push_item(CMD_QUERY, -2048, 2047, 2047, 2047, 255);
		push_item(CMD_RECT, -2048, -2048, 2047, 2047, 255);
		push_item(CMD_RECT, -5, -5, 2047, 2047, 17);
		push_item(CMD_QUERY, 1023, 1023, 0, 0, 0);
		push_item(CMD_RECT, 10, 10, 0, 5, 99);
		push_item(CMD_QUERY, 10, 10, 0, 0, 0);
		push_item(CMD_DISK, 20, 20, 0, 2047, 200);
		push_item(CMD_QUERY, 20, 20, 0, 0, 0);
		push_item(CMD_QUERY, 21, 20, 0, 0, 0);
		push_item(CMD_DISK, 100, 100, 10, 0, 40);
		push_item(CMD_QUERY, 108, 106, 0, 0, 0);
		push_item(CMD_QUERY, 108, 107, 0, 0, 0);
		push_item(CMD_QUERY, 110, 100, 0, 0, 0);
		push_item(CMD_RECT, 200, 200, 3, 4, 60);
		push_item(CMD_QUERY, 202, 203, 0, 0, 0);
		push_item(CMD_QUERY, 203, 200, 0, 0, 0);
		push_item(CMD_QUERY, 200, 204, 0, 0, 0);
		push_item(CMD_DISK, 1023, 0, 2047, 0, 128);
		push_item(CMD_QUERY, 0, 1023, 0, 0, 0);
		push_item(CMD_CLEAR, 0, 0, 0, 0, 0);
		push_item(CMD_QUERY, 100, 100, 0, 0, 0);
		drain();

		// one-pixel image, background from the low byte of all-ones data
		write_reg(CFG_WIDTH, 1);
		write_reg(CFG_HEIGHT, 1);
		write_reg(CFG_BACKGROUND, 2047);
		push_item(CMD_QUERY, 0, 0, 0, 0, 0);
		push_item(CMD_QUERY, 1, 0, 0, 0, 0);
		push_item(CMD_QUERY, 0, 1, 0, 0, 0);
		push_item(CMD_RECT, 0, 0, 1, 1, 3);
		push_item(CMD_QUERY, 0, 0, 0, 0, 0);
		drain();

		// zero dimensions put every pixel outside
		write_reg(CFG_WIDTH, 0);
		push_item(CMD_QUERY, 0, 0, 0, 0, 0);
		drain();
		write_reg(CFG_WIDTH, DIM_CAP);
		write_reg(CFG_HEIGHT, 0);
		push_item(CMD_QUERY, 0, 0, 0, 0, 0);
		drain();

		// dimensions above the cap behave as the cap
		write_reg(CFG_WIDTH, 2047);
		write_reg(CFG_HEIGHT, 2047);
		push_item(CMD_QUERY, 0, 0, 0, 0, 0);
		push_item(CMD_QUERY, 1023, 1023, 0, 0, 0);
		push_item(CMD_QUERY, 1024, 3, 0, 0, 0);
		push_item(CMD_QUERY, 3, 1024, 0, 0, 0);
		push_item(CMD_CLEAR, 0, 0, 0, 0, 0);
		drain();

		for (ph = 0; ph < 7; ph++) begin
			if (ph == 0) begin
				wv = DIM_CAP;
				hv = DIM_CAP;
			end else if (ph == 5) begin
				wv = $urandom_range(1, 2047);
				hv = $urandom_range(1, 2047);
			end else begin
				wv = $urandom_range(16, 300);
				hv = $urandom_range(16, 300);
			end
			write_reg(CFG_WIDTH, wv);
			write_reg(CFG_HEIGHT, hv);
			write_reg(CFG_BACKGROUND, $urandom_range(0, 2047));
			calm = (ph == 1);
			quota = items_made + 140;
			if (ph == 0 || ph == 4) begin
				// overfill the table so appends get refused
				push_item(CMD_CLEAR, 0, 0, 0, 0, 0);
				scene(MAX_FIG + 2 + ph, 14);
			end
			while (items_made < quota)
				scene($urandom_range(0, 10), $urandom_range(4, 16));
			if (ph == 2)
				squeeze_asks++;
			drain();
			calm = 1'b0;
		end

		drain();
		repeat (TAIL_WAIT) @(posedge clk);
		if (errors == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
